// File: src/indexed_list_insert_delete_top_defines.svh
// Assertion macros shared by the RTL. Empty in synthesis builds.
`ifndef INDEXED_LIST_INSERT_DELETE_TOP_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_TOP_DEFINES_SVH

`ifndef SYNTH
// Checked on every rising edge outside reset
`define ILID_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed");
// Checked on every rising edge, reset included
`define ILID_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("assertion failed");
`else
`define ILID_ASSERT(lbl, prop)
`define ILID_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// File: src/ilid_pkg.sv
package ilid_pkg;

   // List depth and derived widths
   localparam int CAPACITY = 64;
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 7;
   localparam int DATA_W   = 32;
   localparam int STAT_W   = 2;
   localparam int OCNT_W   = 7;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [FUNC_W-1:0] {
      OP_READ   = 2'd0,
      OP_INSERT = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic             shift_up;    // insert: open a gap at pos
      logic             shift_down;  // delete: close the gap at pos
      logic [CMP_W-1:0] pos;
   } cmd_type;

endpackage

// File: src/ilid_cell.sv
module ilid_cell
   import ilid_pkg::*;
(
   input  logic                     clock,
   input  cmd_type                  cmd,
   input  logic [IDX_W-1:0]         cell_idx,
   input  logic signed [DATA_W-1:0] left_value,
   input  logic signed [DATA_W-1:0] right_value,
   input  logic signed [DATA_W-1:0] ins_value,
   output logic signed [DATA_W-1:0] value_ff,
   output logic signed [DATA_W-1:0] read_word
);

   logic [CMP_W-1:0]         idx_ext;
   logic                     at_pos;
   logic                     above_pos;
   logic signed [DATA_W-1:0] value_in;

   assign idx_ext   = CMP_W'(cell_idx);
   assign at_pos    = (idx_ext == cmd.pos);
   assign above_pos = (idx_ext > cmd.pos);

   // Local shift: take from the left on insert, from the right on delete
   always_comb begin
      value_in = value_ff;
      if (cmd.shift_up) begin
         if (at_pos) begin
            value_in = ins_value;
         end else if (above_pos) begin
            value_in = left_value;
         end
      end else if (cmd.shift_down) begin
         if (at_pos || above_pos) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   // Contribution to the read bus: only the addressed cell drives
   assign read_word = at_pos ? value_ff : '0;

endmodule

// File: src/ilid_ctrl.sv
`include "indexed_list_insert_delete_top_defines.svh"

module ilid_ctrl
   import ilid_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] read_word,
   output cmd_type                  cmd,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [OCNT_W-1:0]        rsp_count
);

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_read_value_ff, rsp_read_value_in;
   logic [STAT_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [OCNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic                     accept;
   logic [CMP_W-1:0]         pos_ext;
   logic [CMP_W-1:0]         cnt_ext;
   status_type               status;
   logic signed [DATA_W-1:0] rdata;
   logic                     do_up;
   logic                     do_down;

   // A new beat is taken whenever the result register is free or drains
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign pos_ext = CMP_W'(req_position);
   assign cnt_ext = CMP_W'(count_ff);

   // Decode the operation against the current fill
   always_comb begin
      status  = ST_RANGE;
      rdata   = '0;
      do_up   = 1'b0;
      do_down = 1'b0;
      unique case (op_type'(req_func))
         OP_READ: begin
            if (pos_ext < cnt_ext) begin
               status = ST_DONE;
               rdata  = read_word;
            end
         end
         OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status = ST_RANGE;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               status = ST_FULL;
            end else begin
               status = ST_DONE;
               do_up  = 1'b1;
            end
         end
         OP_DELETE: begin
            if (pos_ext < cnt_ext) begin
               status  = ST_DONE;
               do_down = 1'b1;
            end
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
   end

   // Broadcast to the cells, gated by the handshake
   assign cmd.shift_up   = accept && do_up;
   assign cmd.shift_down = accept && do_down;
   assign cmd.pos        = pos_ext;

   // Fill count and result register
   always_comb begin
      count_in          = count_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_read_value_in = rsp_read_value_ff;
      rsp_status_in     = rsp_status_ff;
      rsp_count_in      = rsp_count_ff;
      if (cmd.shift_up) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.shift_down) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_valid_in      = 1'b1;
         rsp_read_value_in = rdata;
         rsp_status_in     = status;
         rsp_count_in      = OCNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_read_value_ff <= rsp_read_value_in;
      rsp_status_ff     <= rsp_status_in;
      rsp_count_ff      <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_count      = rsp_count_ff;

   // Checks
   `ILID_ASSERT(a_count_bound, count_ff <= CNT_W'(CAPACITY))
   `ILID_ASSERT_ALWAYS(a_shift_excl, !(cmd.shift_up && cmd.shift_down))
   `ILID_ASSERT(a_insert_grows, cmd.shift_up |=> count_ff == $past(count_ff) + CNT_W'(1))
   `ILID_ASSERT(a_full_at_cap,
      (accept && status == ST_FULL) |=> rsp_status_ff == ST_FULL && count_ff == CNT_W'(CAPACITY))

endmodule

// File: src/indexed_list_insert_delete_top.sv
// Indexed list of signed 32-bit words with insert and delete at a position.
// Request channel (req_valid/req_stall): req_func selects read, insert or
// delete, req_position the list position, req_value the word to insert.
// Response channel (rsp_valid/rsp_stall): one beat per request carrying
// rsp_read_value (zero unless a read succeeds), rsp_status (done, out of
// range, full) and rsp_count, the fill after the operation.
// A response beat follows an accepted request in the next cycle; a request
// can be taken every cycle while req_stall is low. The list is a chain of
// cells, one per entry; an insert or delete moves every affected cell by
// one place in the same cycle, so the cost does not depend on the position.
// A read is served by a one-hot select across the cells.
// Reset (synchronous) empties the list and drops any pending response.
// While the receiver stalls a pending response, req_stall is raised and
// the response holds; one response register decouples the two channels.
module indexed_list_insert_delete_top
   import ilid_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [FUNC_W-1:0]        req_func,
   input  logic [POS_W-1:0]         req_position,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [DATA_W-1:0] rsp_read_value,
   output logic [STAT_W-1:0]        rsp_status,
   output logic [OCNT_W-1:0]        rsp_count
);

   cmd_type                  cmd;
   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] cell_read  [CAPACITY];
   logic signed [DATA_W-1:0] read_word;

   // Chain of cells, each linked to both neighbours
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_value;
      logic signed [DATA_W-1:0] right_value;

      if (i == 0) begin : g_head
         assign left_value = '0;
      end else begin : g_mid_l
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign right_value = '0;
      end else begin : g_mid_r
         assign right_value = cell_value[i+1];
      end

      ilid_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_idx    (IDX_W'(i)),
         .left_value  (left_value),
         .right_value (right_value),
         .ins_value   (req_value),
         .value_ff    (cell_value[i]),
         .read_word   (cell_read[i])
      );
   end

   // Merge the one-hot read contributions
   always_comb begin
      read_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_word = read_word | cell_read[i];
      end
   end

   ilid_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_position   (req_position),
      .read_word      (read_word),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import ilid_pkg::*;

   // func value with no operation behind it
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam logic [POS_W-1:0]  POS_TOP     = '1;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_value;
      status_type               status;
      logic [OCNT_W-1:0]        count;
   } list_result_type;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [FUNC_W-1:0]        req_func;
   logic [POS_W-1:0]         req_position;
   logic signed [DATA_W-1:0] req_value;
   logic                     rsp_valid;
   logic                     rsp_stall;
   logic signed [DATA_W-1:0] rsp_read_value;
   logic [STAT_W-1:0]        rsp_status;
   logic [OCNT_W-1:0]        rsp_count;

   // Shadow copy of the list
   logic signed [DATA_W-1:0] list_mem [CAPACITY];
   int                       list_fill;
   list_result_type          pending_results [$];

   int failures;
   int n_beats;
   int n_done, n_range, n_full;

   // Pacing knobs, set per test
   int burst_max, gap_max, stall_max;
   int burst_left;

   indexed_list_insert_delete_top DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_position   (req_position),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_count      (rsp_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   // Apply one operation to the shadow list and return the response it gives
   function automatic list_result_type apply_list_op(logic [FUNC_W-1:0] func,
                                                     logic [POS_W-1:0] pos,
                                                     logic signed [DATA_W-1:0] val);
      list_result_type r;
      int              i;
      r.read_value = '0;
      r.status     = ST_DONE;
      case (func)
         OP_READ: begin
            if (pos < list_fill) r.read_value = list_mem[pos[IDX_W-1:0]];
            else r.status = ST_RANGE;
         end
         OP_INSERT: begin
            if (pos > list_fill) begin
               r.status = ST_RANGE;
            end else if (list_fill >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               for (i = list_fill; i > pos; i--) list_mem[i] = list_mem[i-1];
               list_mem[pos[IDX_W-1:0]] = val;
               list_fill++;
            end
         end
         OP_DELETE: begin
            if (pos < list_fill) begin
               for (i = pos; i + 1 < list_fill; i++) list_mem[i] = list_mem[i+1];
               list_fill--;
            end else begin
               r.status = ST_RANGE;
            end
         end
         default: r.status = ST_RANGE;
      endcase
      r.count = list_fill[OCNT_W-1:0];
      case (r.status)
         ST_DONE:  n_done++;
         ST_FULL:  n_full++;
         default:  n_range++;
      endcase
      return r;
   endfunction

   // Present one beat, hold it until taken, then maybe pause the sender
   task automatic issue_list_op(logic [FUNC_W-1:0] func, logic [POS_W-1:0] pos,
                                logic signed [DATA_W-1:0] val);
      int gap;
      @(negedge clock);
      req_valid    <= 1'b1;
      req_func     <= func;
      req_position <= pos;
      req_value    <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(apply_list_op(func, pos, val));
      burst_left--;
      if (burst_left <= 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, burst_max);
      end
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -32'sd1;
         3: return 32'sd0;
         default: return $urandom;
      endcase
   endfunction

   // One random operation; mostly legal positions, with head and tail favoured
   task automatic random_list_op(int ins_pct, int del_pct, int noise_pct);
      logic [FUNC_W-1:0] func;
      logic [POS_W-1:0]  pos;
      int                roll;
      int                hi;
      roll = $urandom_range(0, 99);
      if (roll < noise_pct) begin
         func = FUNC_W'($urandom_range(0, 3));
         pos  = POS_W'($urandom_range(0, 127));
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < ins_pct) func = OP_INSERT;
         else if (roll < ins_pct + del_pct) func = OP_DELETE;
         else func = OP_READ;
         hi = (func == OP_INSERT) ? list_fill : ((list_fill > 0) ? list_fill - 1 : 0);
         case ($urandom_range(0, 3))
            0: pos = '0;
            1: pos = POS_W'(hi);
            default: pos = POS_W'($urandom_range(0, hi));
         endcase
      end
      issue_list_op(func, pos, pick_value());
   endtask

   task automatic set_pacing(int bmax, int gmax, int smax);
      burst_max  = bmax;
      gap_max    = gmax;
      stall_max  = smax;
      burst_left = $urandom_range(1, bmax);
   endtask

   // Hand-picked edges: empty list, head, tail, middle, extremes, bad func
   task automatic test_directed();
      int i;
      set_pacing(4, 2, 3);
      issue_list_op(OP_READ, '0, '0);
      issue_list_op(OP_DELETE, '0, '0);
      issue_list_op(OP_DELETE, POS_TOP, '0);
      issue_list_op(FUNC_UNUSED, '0, 32'sd5);
      issue_list_op(OP_INSERT, 7'd1, 32'sd9);
      issue_list_op(OP_INSERT, 7'd0, 32'sh7fff_ffff);
      issue_list_op(OP_INSERT, 7'd1, 32'sh8000_0000);
      issue_list_op(OP_INSERT, 7'd0, -32'sd1);
      issue_list_op(OP_INSERT, 7'd1, 32'sd0);
      issue_list_op(OP_INSERT, 7'd5, 32'sd3);
      issue_list_op(OP_INSERT, POS_TOP, 32'sd3);
      for (i = 0; i < 5; i++) issue_list_op(OP_READ, POS_W'(i), '0);
      issue_list_op(OP_READ, POS_TOP, '0);
      issue_list_op(OP_DELETE, 7'd1, '0);
      issue_list_op(OP_DELETE, 7'd0, '0);
      issue_list_op(OP_DELETE, 7'd1, '0);
      issue_list_op(OP_READ, 7'd0, '0);
      issue_list_op(FUNC_UNUSED, POS_TOP, -32'sd1);
      issue_list_op(OP_DELETE, 7'd0, '0);
      issue_list_op(OP_READ, 7'd0, '0);
   endtask

   // Back-to-back traffic, no idling on either side
   task automatic test_streaming_mix();
      set_pacing(1000, 0, 0);
      repeat (120) random_list_op(50, 20, 5);
   endtask

   // Insert-heavy run that fills the list and keeps hitting the full case
   task automatic test_fill_to_capacity();
      set_pacing(8, 3, 4);
      repeat (150) random_list_op(80, 5, 5);
   endtask

   // Delete-heavy run down to empty under heavy receiver stalls
   task automatic test_drain_under_stall();
      set_pacing(5, 4, 12);
      repeat (120) random_list_op(15, 65, 5);
   endtask

   // Out-of-range positions and the unused func mixed into normal traffic
   task automatic test_noisy_traffic();
      set_pacing(6, 5, 6);
      repeat (110) random_list_op(40, 35, 30);
   endtask

   // Receiver: alternating ready and stall runs of random length
   initial begin : receiver
      bit stalling;
      int run_left;
      stalling  = 1'b0;
      run_left  = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (run_left > 0) begin
            run_left--;
         end else if (stall_max == 0) begin
            stalling = 1'b0;
         end else begin
            stalling = !stalling;
            run_left = stalling ? $urandom_range(0, stall_max - 1) : $urandom_range(0, 5);
         end
         rsp_stall <= stalling;
      end
   end

   // Response checker
   always @(posedge clock) begin
      list_result_type exp_r;
      if (!reset && rsp_valid && !rsp_stall) begin
         n_beats++;
         if (pending_results.size() == 0) begin
            $error("response beat with no request outstanding");
            failures++;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_read_value !== exp_r.read_value) begin
               $error("read_value: expected %0d, got %0d", exp_r.read_value, rsp_read_value);
               failures++;
            end
            if (rsp_status !== exp_r.status) begin
               $error("status: expected %0d, got %0d", exp_r.status, rsp_status);
               failures++;
            end
            if (rsp_count !== exp_r.count) begin
               $error("count: expected %0d, got %0d", exp_r.count, rsp_count);
               failures++;
            end
         end
      end
   end

   initial begin
      failures     = 0;
      n_beats      = 0;
      n_done       = 0;
      n_range      = 0;
      n_full       = 0;
      list_fill    = 0;
      stall_max    = 0;
      gap_max      = 0;
      burst_max    = 1;
      burst_left   = 1;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = OP_READ;
      req_position = '0;
      req_value    = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_streaming_mix();
      test_fill_to_capacity();
      test_drain_under_stall();
      test_noisy_traffic();

      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (5) @(posedge clock);

      $display("Checked %0d response beats: %0d done, %0d out of range, %0d list full",
               n_beats, n_done, n_range, n_full);
      if (failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
